// File: src/pdr_pkg.sv
// Shared types and constants of the PLL divider ratio calculator.
`default_nettype none
package pdr_pkg;

	localparam int DIV_W = 24;               // width of the shared divider
	localparam int TGT_W = 20;               // target clock width
	localparam int NUM_W = 21;               // 2 * target
	localparam int M_W   = 10;
	localparam int N_W   = 15;
	localparam int ACH_W = 24;
	localparam int HCNT_W = 7;

	localparam logic [TGT_W-1:0] TARGET_MAX_KHZ = 20'd1000000;
	localparam logic [N_W-1:0]   REF_KHZ_TWICE  = 15'd24000;
	localparam logic [DIV_W-1:0] HALF_REF_KHZ   = 24'd12000;
	localparam logic [NUM_W-1:0] M_LIMIT        = 21'd1023;
	localparam logic [HCNT_W-1:0] HALVE_MAX     = 7'd100;
	localparam logic [31:0]      REG_ENABLE_BIT = 32'h8000_0000;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_RANGE   = 2'd1;
	localparam logic [1:0] ST_INVALID = 2'd2;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DIV_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quotient;
		logic [DIV_W-1:0] remainder;
	} div_rsp_t;

endpackage
`default_nettype wire

// File: src/pll_divider_ratio_calc.sv
// Top level: sequencer around the shared divider that works out PLL M and N.
// Timing: a target above 1000000 kHz or a zero target gives its result in the cycle
// after the start transaction. Otherwise the result waits on E Euclid divisions
// (E at most about 20), the M and N divisions, H halving steps (H <= 10) and, unless
// N has halved to zero, the achieved-frequency division, all on the one shared divider.
// Throughput: one transaction at a time; busy stays high until the result strobe.
// Reset: arst_n clears the sequencer, divider control and done; results are not cleared.
`default_nettype none
module pll_divider_ratio_calc (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [19:0] target_khz,
	output logic             done,
	output logic [1:0]       status,
	output logic [9:0]       mult_m,
	output logic [14:0]      div_n,
	output logic [31:0]      reg_word,
	output logic [23:0]      achieved_khz
);
	import pdr_pkg::*;

	// sequencer states
	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_GCD    = 4'd1;  // launch a Euclid step, or finish the GCD
	localparam logic [3:0] S_GCD_W  = 4'd2;
	localparam logic [3:0] S_DM     = 4'd3;  // M = num / g
	localparam logic [3:0] S_DM_W   = 4'd4;
	localparam logic [3:0] S_DN     = 4'd5;  // N = 24000 / g
	localparam logic [3:0] S_DN_W   = 4'd6;
	localparam logic [3:0] S_HALVE  = 4'd7;  // halve M and N while M is too large
	localparam logic [3:0] S_DA     = 4'd8;  // achieved = 12000 * M / N
	localparam logic [3:0] S_DA_W   = 4'd9;

	logic [3:0]        state_q;
	logic [NUM_W-1:0]  num_q;     // 2 * target, kept for the M division
	logic [NUM_W-1:0]  a_q;       // Euclid pair, a ends as the GCD
	logic [NUM_W-1:0]  b_q;
	logic [NUM_W-1:0]  m_q;
	logic [N_W-1:0]    n_q;
	logic [HCNT_W-1:0] hcnt_q;

	logic        done_q;
	logic [1:0]  status_q;
	logic [9:0]  mult_m_q;
	logic [14:0] div_n_q;
	logic [31:0] reg_word_q;
	logic [23:0] ach_q;

	div_req_t         div_req;
	div_rsp_t         div_rsp;
	logic [DIV_W-1:0] ach_num;
	logic [31:0]      word;

	pdr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// M is at most 1023 once halving is over, so the product fits in 24 bits
	assign ach_num = HALF_REF_KHZ * {{(DIV_W-M_W){1'b0}}, m_q[M_W-1:0]};

	// packed register word, wrapping modulo 2^32 when N has reached zero
	assign word = ((32'(m_q[M_W-1:0]) - 32'd1) << 16)
	            | ((32'(n_q) - 32'd1) << 8)
	            | REG_ENABLE_BIT;

	// operand select for the shared divider
	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = '0;
		div_req.divisor  = '0;
		unique case (state_q)
			S_GCD: begin
				div_req.start    = (b_q != '0);
				div_req.dividend = DIV_W'(a_q);
				div_req.divisor  = DIV_W'(b_q);
			end
			S_DM: begin
				div_req.start    = 1'b1;
				div_req.dividend = DIV_W'(num_q);
				div_req.divisor  = DIV_W'(a_q);
			end
			S_DN: begin
				div_req.start    = 1'b1;
				div_req.dividend = DIV_W'(REF_KHZ_TWICE);
				div_req.divisor  = DIV_W'(a_q);
			end
			S_DA: begin
				div_req.start    = 1'b1;
				div_req.dividend = ach_num;
				div_req.divisor  = DIV_W'(n_q);
			end
			default: begin
				div_req.start = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
			hcnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						if (target_khz > TARGET_MAX_KHZ || target_khz == '0) begin
							// reject right away
							done_q <= 1'b1;
						end else begin
							state_q <= S_GCD;
						end
					end
				end
				S_GCD: begin
					if (b_q == '0) begin
						state_q <= S_DM;
					end else begin
						state_q <= S_GCD_W;
					end
				end
				S_GCD_W: begin
					if (div_rsp.done) begin
						state_q <= S_GCD;
					end
				end
				S_DM: state_q <= S_DM_W;
				S_DM_W: begin
					if (div_rsp.done) begin
						state_q <= S_DN;
					end
				end
				S_DN: state_q <= S_DN_W;
				S_DN_W: begin
					if (div_rsp.done) begin
						hcnt_q  <= '0;
						state_q <= S_HALVE;
					end
				end
				S_HALVE: begin
					if (m_q > M_LIMIT && hcnt_q < HALVE_MAX) begin
						hcnt_q <= hcnt_q + 1'b1;
					end else if (n_q == '0) begin
						// divider collapsed: report invalid
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_DA;
					end
				end
				S_DA: state_q <= S_DA_W;
				S_DA_W: begin
					if (div_rsp.done) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath and result registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					num_q <= {target_khz, 1'b0};
					a_q   <= {target_khz, 1'b0};
					b_q   <= NUM_W'(REF_KHZ_TWICE);
					if (target_khz > TARGET_MAX_KHZ || target_khz == '0) begin
						status_q   <= (target_khz == '0) ? ST_INVALID : ST_RANGE;
						mult_m_q   <= '0;
						div_n_q    <= '0;
						reg_word_q <= '0;
						ach_q      <= '0;
					end
				end
			end
			S_GCD_W: begin
				if (div_rsp.done) begin
					a_q <= b_q;
					b_q <= div_rsp.remainder[NUM_W-1:0];
				end
			end
			S_DM_W: begin
				if (div_rsp.done) begin
					m_q <= div_rsp.quotient[NUM_W-1:0];
				end
			end
			S_DN_W: begin
				if (div_rsp.done) begin
					n_q <= div_rsp.quotient[N_W-1:0];
				end
			end
			S_HALVE: begin
				if (m_q > M_LIMIT && hcnt_q < HALVE_MAX) begin
					m_q <= m_q >> 1;
					n_q <= n_q >> 1;
				end else if (n_q == '0) begin
					status_q   <= ST_INVALID;
					mult_m_q   <= m_q[M_W-1:0];
					div_n_q    <= n_q;
					reg_word_q <= word;
					ach_q      <= '0;
				end
			end
			S_DA_W: begin
				if (div_rsp.done) begin
					status_q   <= ST_OK;
					mult_m_q   <= m_q[M_W-1:0];
					div_n_q    <= n_q;
					reg_word_q <= word;
					ach_q      <= div_rsp.quotient[ACH_W-1:0];
				end
			end
			default: begin
				num_q <= num_q;
			end
		endcase
	end

	assign busy         = (state_q != S_IDLE);
	assign done         = done_q;
	assign status       = status_q;
	assign mult_m       = mult_m_q;
	assign div_n        = div_n_q;
	assign reg_word     = reg_word_q;
	assign achieved_khz = ach_q;

`ifndef NO_ASSERTIONS
	// an out-of-range target is answered on the next cycle
	a_range_fast: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && target_khz > TARGET_MAX_KHZ) |=> (done && status == ST_RANGE))
		else $error("out-of-range target not rejected at once");

	// a good result never carries a zero multiplier or divider
	a_ok_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_OK) |-> (mult_m != '0 && div_n != '0))
		else $error("ok result with zero M or N");

	// the divider only finishes while the sequencer waits for it
	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == S_GCD_W || state_q == S_DM_W ||
		                  state_q == S_DN_W || state_q == S_DA_W))
		else $error("divider finished outside a wait state");

	// no result strobe while a transaction is still at work
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");
`endif

endmodule
`default_nettype wire

// File: src/pdr_div.sv
// Shared radix-2 restoring divider, one quotient bit per cycle.
`default_nettype none
module pdr_div (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire pdr_pkg::div_req_t req,
	output pdr_pkg::div_rsp_t     rsp
);
	import pdr_pkg::*;

	localparam int CNT_W = $clog2(DIV_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [DIV_W-1:0] quo_q;
	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] dsr_q;
	logic [DIV_W:0]   shifted;
	logic [DIV_W:0]   trial;
	logic             ge;

	// shift in the next dividend bit and try the subtraction
	assign shifted = {rem_q, quo_q[DIV_W-1]};
	assign trial   = shifted - {1'b0, dsr_q};
	assign ge      = (shifted >= {1'b0, dsr_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q <= CNT_W'(DIV_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dsr_q <= req.divisor;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[DIV_W-2:0], ge};
			rem_q <= ge ? trial[DIV_W-1:0] : shifted[DIV_W-1:0];
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

endmodule
`default_nettype wire

// File: bench/pll_divider_ratio_calc_tb.sv
// Testbench of the PLL divider ratio calculator: directed and random targets, self-checking.
module pll_divider_ratio_calc_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pdr_pkg::*;

	// One expected result: the PLL setting that a target clock maps to.
	typedef struct packed {
		logic [1:0]  status;
		logic [9:0]  mult_m;
		logic [14:0] div_n;
		logic [31:0] reg_word;
		logic [23:0] achieved_khz;
	} pll_setting_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [19:0] target_khz = '0;
	logic        busy;
	logic        done;
	logic [1:0]  status;
	logic [9:0]  mult_m;
	logic [14:0] div_n;
	logic [31:0] reg_word;
	logic [23:0] achieved_khz;

	// Settings still owed by the block, oldest first.
	pll_setting_t pending_settings[$];
	int unsigned  failures = 0;

	pll_divider_ratio_calc u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.target_khz   (target_khz),
		.done         (done),
		.status       (status),
		.mult_m       (mult_m),
		.div_n        (div_n),
		.reg_word     (reg_word),
		.achieved_khz (achieved_khz)
	);

	always #5 clk = ~clk;

	// Work out the PLL setting for one target clock.
	// M/N is 2*target/24000 in lowest terms, then both are halved while M is too big.
	function automatic pll_setting_t pll_setting_for(input logic [19:0] tgt);
		pll_setting_t s;
		logic [31:0]  a, b, r, m, n, word;
		logic [63:0]  ach;
		int unsigned  halvings;
		s = '0;
		if (tgt > TARGET_MAX_KHZ) begin
			s.status = ST_RANGE;
		end else if (tgt == '0) begin
			s.status = ST_INVALID;
		end else begin
			// Euclid on the doubled target and the doubled reference.
			a = 32'(tgt) << 1;
			b = 32'(REF_KHZ_TWICE);
			while (b != 0) begin
				r = a % b;
				a = b;
				b = r;
			end
			m = (32'(tgt) << 1) / a;
			n = 32'(REF_KHZ_TWICE) / a;
			halvings = 0;
			while (m > 32'(M_LIMIT) && halvings < HALVE_MAX) begin
				m = m >> 1;
				n = n >> 1;
				halvings++;
			end
			// N-1 wraps to all ones when N has dropped to zero.
			word = ((m - 32'd1) << 16) | ((n - 32'd1) << 8) | REG_ENABLE_BIT;
			if (n == 0) begin
				s.status = ST_INVALID;
			end else begin
				s.status = ST_OK;
				ach = (64'(HALF_REF_KHZ) * 64'(m)) / 64'(n);
				s.achieved_khz = ach[23:0];
			end
			s.mult_m = m[9:0];
			s.div_n = n[14:0];
			s.reg_word = word;
		end
		return s;
	endfunction

	// Count a failure; only the first ten get a full line.
	task automatic log_failure(input string what);
		failures++;
		if (failures <= 10)
			$display("[%0t] MISMATCH %s", $time, what);
	endtask

	// Drive one target and hold it until the block takes it.
	// Start is left high: the caller lowers it when it idles, so that back-to-back
	// transactions never lower and raise start in the same time step.
	task automatic issue_target(input logic [19:0] tgt);
		start <= 1'b1;
		target_khz <= tgt;
		do
			@(posedge clk);
		while (busy);
		pending_settings.push_back(pll_setting_for(tgt));
	endtask

	// Drop start for a burst of idle cycles.
	task automatic idle_for(input int unsigned cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Hold off the next transaction until every result is in.
	task automatic wait_all_done();
		start <= 1'b0;
		@(posedge clk);
		while (pending_settings.size() != 0)
			@(posedge clk);
	endtask

	// Pick a target, biased toward the interesting regions.
	function automatic logic [19:0] random_target();
		int unsigned sel;
		sel = $urandom_range(0, 99);
		if (sel < 5)
			return '0;
		else if (sel < 13)
			return 20'($urandom_range(32'(TARGET_MAX_KHZ) + 1, 20'hFFFFF));
		else if (sel < 16)
			return TARGET_MAX_KHZ;
		else if (sel < 24)
			return 20'($urandom_range(1, 64));
		else if (sel < 38)
			return 20'(1000 * $urandom_range(1, 1000));   // large common divisors
		else if (sel < 46)
			return 20'(12 * $urandom_range(1, 2000));      // around the M limit
		else
			return 20'($urandom_range(1, 32'(TARGET_MAX_KHZ)));
	endfunction

	// Check each result strobe against the oldest pending setting.
	always @(posedge clk) begin
		pll_setting_t got, want;
		if (arst_n && done) begin
			got = '{status, mult_m, div_n, reg_word, achieved_khz};
			if (pending_settings.size() == 0) begin
				log_failure($sformatf("unexpected result st=%0d m=%0d n=%0d word=%h ach=%0d",
					got.status, got.mult_m, got.div_n, got.reg_word, got.achieved_khz));
			end else begin
				want = pending_settings.pop_front();
				if (got.status !== want.status || got.mult_m !== want.mult_m ||
						got.div_n !== want.div_n || got.reg_word !== want.reg_word ||
						got.achieved_khz !== want.achieved_khz)
					log_failure($sformatf(
						"exp st=%0d m=%0d n=%0d word=%h ach=%0d, got st=%0d m=%0d n=%0d word=%h ach=%0d",
						want.status, want.mult_m, want.div_n, want.reg_word, want.achieved_khz,
						got.status, got.mult_m, got.div_n, got.reg_word, got.achieved_khz));
			end
		end
	end

	// Corners: zero, the range limit and just past it, all ones, M landing exactly
	// on its limit, a unit ratio, heavy halving and alternating bit patterns.
	task automatic test_corner_targets();
		logic [19:0] corners[14];
		corners = '{20'd0, 20'd1, 20'd2, 20'd7, 20'd12000, 20'd24000, 20'd12276,
			20'd12288, 20'd999999, TARGET_MAX_KHZ, TARGET_MAX_KHZ + 20'd1,
			20'hFFFFF, 20'h55555, 20'hAAAAA};
		foreach (corners[i])
			issue_target(corners[i]);
		wait_all_done();
	endtask

	// Random targets with idle bursts; hold off twice until everything has drained.
	task automatic test_random_targets();
		for (int i = 0; i < 900; i++) begin
			if ($urandom_range(0, 3) == 0)
				idle_for($urandom_range(1, 12));
			issue_target(random_target());
			if (i == 300 || i == 600)
				wait_all_done();
		end
	endtask

	// Random targets back to back, start held high throughout.
	task automatic test_back_to_back();
		for (int i = 0; i < 140; i++)
			issue_target(random_target());
		start <= 1'b0;
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_corner_targets();
		test_random_targets();
		test_back_to_back();

		// Drain, then leave room for any stray strobe.
		while (pending_settings.size() != 0)
			@(posedge clk);
		repeat (450) @(posedge clk);

		if (failures == 0 && pending_settings.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// Hang guard: far beyond the slowest correct run.
	initial begin
		#25ms;
		$display("simulation failed");
		$finish;
	end

endmodule
